### sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define LCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcs check failed");

// Next-cycle implication, disabled while reset is held
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcs check failed");

// Next-cycle implication that also holds across reset
`define LCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lcs check failed");

`endif

### sv/lcs_pkg.sv
// Types and constants of the LED column scroll engine
package lcs_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int LENGTH_W    = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAME_OUT_W = 56;
    localparam int FRAME_PAD_W = 64;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_DELAY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_TIMES  = 2'd2;

    localparam logic [LENGTH_W-1:0] SCROLL_LENGTH_RST = 9'd1;
    localparam logic [BYTE_W-1:0]   SHIFT_DELAY_RST   = 8'd10;
    localparam logic [BYTE_W-1:0]   REPEAT_TIMES_RST  = 8'd0;
    localparam logic [BYTE_W-1:0]   PASS_MAX          = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] column_index;
        logic [BYTE_W-1:0] column_bits;
        logic [BYTE_W-1:0] pixel_row;
        logic [BYTE_W-1:0] pixel_col;
        logic              pixel_on;
    } item_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] scroll_length;
        logic [BYTE_W-1:0]   shift_delay;
        logic [BYTE_W-1:0]   repeat_times;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame_bits;
        logic                   scrolling;
    } result_t;

endpackage

### sv/lcs_ram.sv
// Generic single-port-write, registered-read RAM
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/lcs_core.sv
// Frame, scroll counters and scroll memory; applies one command per step
module lcs_core import lcs_pkg::*; #(
    parameter int GROUP_COUNT  = 8,
    parameter int GROUP_HEIGHT = 7,
    parameter int SCROLL_DEPTH = 256
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int POS_W   = $clog2(SCROLL_DEPTH);
    localparam int FRAME_W = GROUP_COUNT * GROUP_HEIGHT;

    logic [GROUP_HEIGHT-1:0] frame_reg  [GROUP_COUNT];
    logic [GROUP_HEIGHT-1:0] frame_next [GROUP_COUNT];
    logic [BYTE_W-1:0]       delay_reg, delay_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [BYTE_W-1:0]       pass_reg, pass_next;
    logic                    active_reg, active_next;

    logic                    mem_we;
    logic [POS_W-1:0]        mem_waddr;
    logic [BYTE_W-1:0]       mem_rdata;
    logic                    byp_valid_reg;
    logic [BYTE_W-1:0]       byp_data_reg;
    logic [BYTE_W-1:0]       column;
    logic [LENGTH_W-1:0]     scroll_len;
    logic [FRAME_W-1:0]      frame_flat;

    assign mem_waddr = item.column_index[POS_W-1:0];

    // Read address follows the next position, so the column is ready for the next tick
    lcs_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(SCROLL_DEPTH)
    ) u_scroll_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(item.column_bits),
        .raddr(pos_next),
        .rdata(mem_rdata)
    );

    // A load to the address being read lands in the bypass register
    assign column = byp_valid_reg ? byp_data_reg : mem_rdata;

    always_comb begin
        if (cfg.scroll_length > LENGTH_W'(SCROLL_DEPTH)) begin
            scroll_len = LENGTH_W'(SCROLL_DEPTH);
        end else if (cfg.scroll_length == '0) begin
            scroll_len = LENGTH_W'(1);
        end else begin
            scroll_len = cfg.scroll_length;
        end
    end

    always_comb begin
        logic [BYTE_W:0]     delay_inc;
        logic [LENGTH_W-1:0] pos_inc;
        logic [BYTE_W-1:0]   pass_inc;

        frame_next  = frame_reg;
        delay_next  = delay_reg;
        pos_next    = pos_reg;
        pass_next   = pass_reg;
        active_next = active_reg;
        mem_we      = 1'b0;
        delay_inc   = (BYTE_W+1)'(delay_reg) + (BYTE_W+1)'(1);
        pos_inc     = LENGTH_W'(pos_reg) + LENGTH_W'(1);
        pass_inc    = (pass_reg == PASS_MAX) ? PASS_MAX : pass_reg + BYTE_W'(1);

        if (step) begin
            unique case (item.command)
                CMD_TICK: begin
                    if (active_reg) begin
                        if (delay_inc >= (BYTE_W+1)'(cfg.shift_delay)) begin
                            delay_next = '0;
                            for (int g = 0; g < GROUP_COUNT - 1; g++) begin
                                frame_next[g] = frame_reg[g+1];
                            end
                            frame_next[GROUP_COUNT-1] = column[GROUP_HEIGHT-1:0];
                            if (pos_inc >= scroll_len) begin
                                pos_next = '0;
                                if (cfg.repeat_times != '0) begin
                                    pass_next = pass_inc;
                                    if (pass_inc >= cfg.repeat_times) begin
                                        active_next = 1'b0;
                                        for (int g = 0; g < GROUP_COUNT; g++) begin
                                            frame_next[g] = '0;
                                        end
                                    end
                                end
                            end else begin
                                pos_next = pos_inc[POS_W-1:0];
                            end
                        end else begin
                            delay_next = delay_inc[BYTE_W-1:0];
                        end
                    end
                end
                CMD_LOAD: begin
                    mem_we = (9'(item.column_index) < 9'(SCROLL_DEPTH));
                end
                CMD_PIXEL: begin
                    for (int g = 0; g < GROUP_COUNT; g++) begin
                        for (int l = 0; l < GROUP_HEIGHT; l++) begin
                            if (item.pixel_row == BYTE_W'(g) && item.pixel_col == BYTE_W'(l)) begin
                                frame_next[g][l] = item.pixel_on;
                            end
                        end
                    end
                end
                CMD_START: begin
                    if (active_reg) begin
                        for (int g = 0; g < GROUP_COUNT; g++) begin
                            frame_next[g] = '0;
                        end
                    end
                    delay_next  = '0;
                    pos_next    = '0;
                    pass_next   = '0;
                    active_next = 1'b1;
                end
                CMD_STOP: begin
                    active_next = 1'b0;
                    for (int g = 0; g < GROUP_COUNT; g++) begin
                        frame_next[g] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                frame_reg[g] <= '0;
            end
            delay_reg     <= '0;
            pos_reg       <= '0;
            pass_reg      <= '0;
            active_reg    <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            frame_reg     <= frame_next;
            delay_reg     <= delay_next;
            pos_reg       <= pos_next;
            pass_reg      <= pass_next;
            active_reg    <= active_next;
            byp_valid_reg <= mem_we && (mem_waddr == pos_next);
        end
        byp_data_reg <= item.column_bits;
    end

    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            frame_flat[g*GROUP_HEIGHT +: GROUP_HEIGHT] = frame_next[g];
        end
    end

    always_comb begin
        logic [FRAME_PAD_W-1:0] frame_pad;

        frame_pad         = FRAME_PAD_W'(frame_flat);
        result.frame_bits = frame_pad[FRAME_OUT_W-1:0];
        result.scrolling  = active_next;
    end

endmodule

### sv/led_column_scroll_engine.sv
// LED column scroll engine: input register, state update and result register
//
// Usage: every item on the s_ channel carries one command (tick, load a scroll
// column, write a pixel, start, stop) and yields exactly one result item on the
// m_ channel: the full frame after the command and the scrolling flag.
// Path: an accepted item waits in the input register, then its result is held
// in the result register, where m_valid shows it; while that register is full
// and m_ready is low, the item stays in the input register.
// Throughput: one item per clock while m_ready is high; the whole frame,
// counters and scroll memory port update as an item leaves the input register.
// The scroll memory read is prefetched at the next scroll position, so a shift
// never waits for the memory.
// Stall: while m_ready is low the result register holds and one more item
// can wait in the input register; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) empties both registers, clears the frame,
// the counters and the scrolling flag and restores the configuration
// registers. Scroll memory contents are not cleared; columns must be loaded
// before they are scrolled. Configuration is written through cfg_we.
module led_column_scroll_engine import lcs_pkg::*; #(
    parameter int GROUP_COUNT  = 8,
    parameter int GROUP_HEIGHT = 7,
    parameter int SCROLL_DEPTH = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [BYTE_W-1:0]      s_column_index,
    input  logic [BYTE_W-1:0]      s_column_bits,
    input  logic [BYTE_W-1:0]      s_pixel_row,
    input  logic [BYTE_W-1:0]      s_pixel_col,
    input  logic                   s_pixel_on,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FRAME_OUT_W-1:0] m_frame_bits,
    output logic                   m_scrolling,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    cfg_t    cfg_reg;
    result_t core_result;
    logic    process;
    logic    s_take;

    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (process) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_take) begin
            in_item_reg.command      <= s_command;
            in_item_reg.column_index <= s_column_index;
            in_item_reg.column_bits  <= s_column_bits;
            in_item_reg.pixel_row    <= s_pixel_row;
            in_item_reg.pixel_col    <= s_pixel_col;
            in_item_reg.pixel_on     <= s_pixel_on;
        end
        if (process) begin
            out_result_reg <= core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scroll_length <= SCROLL_LENGTH_RST;
            cfg_reg.shift_delay   <= SHIFT_DELAY_RST;
            cfg_reg.repeat_times  <= REPEAT_TIMES_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCROLL_LENGTH: cfg_reg.scroll_length <= cfg_wdata[LENGTH_W-1:0];
                REG_SHIFT_DELAY:   cfg_reg.shift_delay   <= cfg_wdata[BYTE_W-1:0];
                REG_REPEAT_TIMES:  cfg_reg.repeat_times  <= cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lcs_core #(
        .GROUP_COUNT (GROUP_COUNT),
        .GROUP_HEIGHT(GROUP_HEIGHT),
        .SCROLL_DEPTH(SCROLL_DEPTH)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (process),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign m_valid      = out_valid_reg;
    assign m_frame_bits = out_result_reg.frame_bits;
    assign m_scrolling  = out_result_reg.scrolling;

endmodule

### sv/lcs_checker.sv
// Port-level checks of the LED column scroll engine, bound to the top level
`include "assert_macros.svh"

module lcs_checker import lcs_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [FRAME_OUT_W-1:0] m_frame_bits,
    input logic                   m_scrolling
);

    // A stalled result holds its value
    `LCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_bits) && $stable(m_scrolling))

    // With the result register empty the input side always has room
    `LCS_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // A result taken downstream frees a slot for a new item in the same cycle
    `LCS_ASSERT_IMPLY(a_ready_on_drain, aclk, aresetn, m_valid && m_ready, s_ready)

    // Reset empties both registers
    `LCS_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind led_column_scroll_engine lcs_checker u_lcs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_frame_bits(m_frame_bits),
    .m_scrolling (m_scrolling)
);

### dv/tb.sv
// Testbench for the LED column scroll engine: queued stimulus, in-order frame checking
module tb import lcs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUPS      = 8;
    localparam int LEDS        = 7;
    localparam int COLUMNS     = 256;
    localparam int STALL_LIMIT = 2000;
    // command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command;
    logic [BYTE_W-1:0]      s_column_index;
    logic [BYTE_W-1:0]      s_column_bits;
    logic [BYTE_W-1:0]      s_pixel_row;
    logic [BYTE_W-1:0]      s_pixel_col;
    logic                   s_pixel_on;
    logic                   m_valid;
    logic                   m_ready;
    logic [FRAME_OUT_W-1:0] m_frame_bits;
    logic                   m_scrolling;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    led_column_scroll_engine i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_column_index (s_column_index),
        .s_column_bits  (s_column_bits),
        .s_pixel_row    (s_pixel_row),
        .s_pixel_col    (s_pixel_col),
        .s_pixel_on     (s_pixel_on),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_bits   (m_frame_bits),
        .m_scrolling    (m_scrolling),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    item_t   pending_cmds[$];
    result_t frames_due[$];
    item_t   drive_cmd;
    result_t want;

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int frames_checked;
    int items_sent;
    int settings_run;
    int stall_cycles;
    bit s_took;

    // predicted block state
    logic [LEDS-1:0]       lit_groups [GROUPS];
    logic [BYTE_W-1:0]     column_store [COLUMNS];
    bit                    column_loaded [COLUMNS];
    int                    tick_count;
    int                    column_pos;
    int                    passes_done;
    bit                    scroll_on;
    logic [LENGTH_W-1:0]   len_set;
    logic [BYTE_W-1:0]     delay_set;
    logic [BYTE_W-1:0]     repeat_set;

    always #5 aclk = ~aclk;

    // queue an item and work out the frame it should produce
    task automatic send_and_predict(input item_t it);
        result_t res;
        int      eff_len;
        int      g;
        pending_cmds.push_back(it);
        items_sent++;
        eff_len = (len_set > COLUMNS) ? COLUMNS : int'(len_set);
        case (it.command)
            CMD_TICK: begin
                if (scroll_on) begin
                    tick_count++;
                    if (tick_count >= delay_set) begin
                        tick_count = 0;
                        for (g = 0; g < GROUPS - 1; g++)
                            lit_groups[g] = lit_groups[g + 1];
                        lit_groups[GROUPS - 1] = column_store[column_pos][LEDS-1:0];
                        column_pos++;
                        // a length of zero wraps like a length of one
                        if (column_pos >= eff_len) begin
                            column_pos = 0;
                            if (repeat_set != 0) begin
                                if (passes_done < PASS_MAX)
                                    passes_done++;
                                if (passes_done >= repeat_set) begin
                                    scroll_on = 1'b0;
                                    lit_groups = '{default: '0};
                                end
                            end
                        end
                    end
                end
            end
            CMD_LOAD: begin
                column_store[it.column_index] = it.column_bits;
                column_loaded[it.column_index] = 1'b1;
            end
            CMD_PIXEL: begin
                if (it.pixel_row < GROUPS && it.pixel_col < LEDS)
                    lit_groups[it.pixel_row][it.pixel_col] = it.pixel_on;
            end
            CMD_START: begin
                if (scroll_on)
                    lit_groups = '{default: '0};
                tick_count = 0;
                column_pos = 0;
                passes_done = 0;
                scroll_on = 1'b1;
            end
            CMD_STOP: begin
                scroll_on = 1'b0;
                lit_groups = '{default: '0};
            end
            default: ;
        endcase
        res.scrolling = scroll_on;
        for (g = 0; g < GROUPS; g++)
            res.frame_bits[g*LEDS +: LEDS] = lit_groups[g];
        frames_due.push_back(res);
    endtask

    // a tick that would shift in a never-loaded column gets a load in front of it
    task automatic issue(input item_t it);
        item_t fill;
        if (it.command == CMD_TICK && scroll_on && tick_count + 1 >= delay_set
            && !column_loaded[column_pos]) begin
            fill = it;
            fill.command = CMD_LOAD;
            fill.column_index = column_pos[BYTE_W-1:0];
            fill.column_bits = BYTE_W'($urandom_range(0, 255));
            send_and_predict(fill);
        end
        send_and_predict(it);
    endtask

    function automatic item_t make_item(input logic [CMD_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] idx,
                                        input logic [BYTE_W-1:0] bits,
                                        input logic [BYTE_W-1:0] row,
                                        input logic [BYTE_W-1:0] col,
                                        input logic on);
        item_t it;
        it.command = cmd;
        it.column_index = idx;
        it.column_bits = bits;
        it.pixel_row = row;
        it.pixel_col = col;
        it.pixel_on = on;
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || frames_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCROLL_LENGTH: len_set = val[LENGTH_W-1:0];
            REG_SHIFT_DELAY:   delay_set = val[BYTE_W-1:0];
            REG_REPEAT_TIMES:  repeat_set = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // calm: no start or stop while scrolling, so long delays and pass counts play out
    task automatic run_phase(input int unsigned len, input int unsigned dly,
                             input int unsigned rpt, input int budget,
                             input int tick_pct, input bit calm);
        item_t it;
        int    counted;
        bit    ignored;
        wait_idle();
        write_reg(REG_SCROLL_LENGTH, len);
        write_reg(REG_SHIFT_DELAY, dly);
        write_reg(REG_REPEAT_TIMES, rpt);
        settings_run++;
        counted = 0;
        while (counted < budget) begin
            it.column_index = BYTE_W'($urandom_range(0, 255));
            it.column_bits = BYTE_W'($urandom_range(0, 255));
            it.pixel_row = BYTE_W'($urandom_range(0, 255));
            it.pixel_col = BYTE_W'($urandom_range(0, 255));
            it.pixel_on = 1'($urandom_range(0, 1));
            if (!scroll_on && $urandom_range(0, 99) < 40) begin
                it.command = CMD_START;
            end else if ($urandom_range(0, 99) < tick_pct) begin
                it.command = CMD_TICK;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        it.command = CMD_LOAD;
                        if ($urandom_range(0, 99) < 60)
                            it.column_index = BYTE_W'($urandom_range(0,
                                (len > COLUMNS || len == 0) ? COLUMNS - 1 : len - 1));
                    end
                    3, 4, 5: begin
                        it.command = CMD_PIXEL;
                        if ($urandom_range(0, 99) < 70) begin
                            it.pixel_row = BYTE_W'($urandom_range(0, GROUPS - 1));
                            it.pixel_col = BYTE_W'($urandom_range(0, LEDS - 1));
                        end
                    end
                    6: it.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                    7: it.command = (calm && scroll_on) ? CMD_PIXEL : CMD_START;
                    8: it.command = (calm && scroll_on) ? CMD_LOAD : CMD_STOP;
                    default: it.command = CMD_TICK;
                endcase
            end
            ignored = (it.command == CMD_TICK && !scroll_on) || it.command >= CMD_SPARE_FIRST;
            issue(it);
            if (!ignored)
                counted++;
        end
    endtask

    // driver: next item goes out at the falling edge once the previous one was taken
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_took)) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                drive_cmd = pending_cmds.pop_front();
                s_command <= drive_cmd.command;
                s_column_index <= drive_cmd.column_index;
                s_column_bits <= drive_cmd.column_bits;
                s_pixel_row <= drive_cmd.pixel_row;
                s_pixel_col <= drive_cmd.pixel_col;
                s_pixel_on <= drive_cmd.pixel_on;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t: result with no item pending: frame %h scrolling %b",
                         $time, m_frame_bits, m_scrolling);
                mismatches++;
            end else begin
                want = frames_due.pop_front();
                if (m_frame_bits !== want.frame_bits) begin
                    $display("%0t: frame_bits expected %h actual %h",
                             $time, want.frame_bits, m_frame_bits);
                    mismatches++;
                end
                if (m_scrolling !== want.scrolling) begin
                    $display("%0t: scrolling expected %b actual %b",
                             $time, want.scrolling, m_scrolling);
                    mismatches++;
                end
                frames_checked++;
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_TICK;
        s_column_index = '0;
        s_column_bits = '0;
        s_pixel_row = '0;
        s_pixel_col = '0;
        s_pixel_on = 1'b0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SCROLL_LENGTH;
        cfg_wdata = '0;
        s_took = 1'b0;
        stall_cycles = 0;
        mismatches = 0;
        frames_checked = 0;
        items_sent = 0;
        settings_run = 1;
        src_idle_pct = 23;
        sink_idle_pct = 76;

        lit_groups = '{default: '0};
        column_loaded = '{default: 1'b0};
        column_store = '{default: '0};
        tick_count = 0;
        column_pos = 0;
        passes_done = 0;
        scroll_on = 1'b0;
        len_set = SCROLL_LENGTH_RST;
        delay_set = SHIFT_DELAY_RST;
        repeat_set = REPEAT_TIMES_RST;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed edge cases under the reset configuration
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd7, 8'd6, 1'b1));
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd8, 8'd0, 1'b1));
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd7, 1'b1));
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'hFF, 8'hFF, 1'b1));
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd7, 8'd6, 1'b0));
        issue(make_item(CMD_LOAD, 8'd0, 8'hFF, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_LOAD, 8'hFF, 8'h80, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_SPARE_FIRST, 8'hFF, 8'hFF, 8'd1, 8'd1, 1'b1));
        issue(make_item(CMD_STOP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_PIXEL, 8'd0, 8'd0, 8'd3, 8'd2, 1'b1));
        // start from idle keeps the frame; tenth tick shifts column 0 in
        issue(make_item(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        repeat (10) issue(make_item(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_SPARE_LAST, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        issue(make_item(CMD_STOP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));

        run_phase(0, 0, 0, 60, 55, 1'b0);
        run_phase(3, 1, 2, 80, 55, 1'b0);
        run_phase(256, 0, 0, 100, 55, 1'b0);

        wait_idle();
        src_idle_pct = 76;
        sink_idle_pct = 23;
        run_phase(511, 2, 3, 50, 55, 1'b0);
        // one pass per tick until the pass count reaches its top
        run_phase(1, 0, 255, 290, 95, 1'b1);

        wait_idle();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_phase(5, 255, 1, 270, 95, 1'b1);

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("summary: %0d items sent, %0d frames checked, %0d register settings",
                 items_sent, frames_checked, settings_run);
        $display("summary: pixel, load, start, stop and tick traffic under three stall mixes");
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/lcs_pkg.sv
sv/lcs_ram.sv
sv/lcs_core.sv
sv/led_column_scroll_engine.sv
sv/lcs_checker.sv
dv/tb.sv
